/* design/rafp_pkg.sv */
// Shared types, constants and helpers for the rangefinder ASCII frame parser.
package rafp_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int MIN_FRAME_BYTES = 3;
    localparam int KW_LEN = 6;
    localparam int KW_W = 3;
    localparam int DIST_W = 16;
    localparam int PROD_W = DIST_W + 4;
    localparam logic [15:0] INF_DIST_RESET = 16'hFFFF;
    localparam logic [15:0] STATUS_FAIL_CODE = 16'd2;

    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_E = 8'h65;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_D = 8'h64;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_SPACES = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FAIL  = 2'd1,
        ST_ERROR = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] distance;
    } t_out_beat;

    typedef struct packed {
        logic      last;
        t_out_beat res;
    } t_frame_res;

    function automatic logic [7:0] keyword_char(input logic [KW_W-1:0] p);
        logic [7:0] ch;
        case (p)
            3'd0: ch = CH_S;
            3'd1: ch = CH_T;
            3'd2: ch = CH_A;
            3'd3: ch = CH_T;
            3'd4: ch = CH_E;
            3'd5: ch = CH_SEMI;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

/* design/rangefinder_ascii_frame_parser_core.sv */
// Top level of the rangefinder ASCII frame parser with its beat handshakes.
// One input beat is accepted every cycle when the result side is not stalled.
// A result appears once the beat that ends its frame has passed from the input register
// into the result register; a stalled result side can hold that beat in the input register.
// The parse state advances once per beat through a single compare and add stage.
// Synchronous reset clears all frame state and sets the distance limit to 65535.
module rangefinder_ascii_frame_parser_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  rafp_pkg::t_in_beat    i_in_beat,
    output logic                  o_valid,
    input  logic                  i_stall,
    output rafp_pkg::t_out_beat   o_out_beat,
    input  logic                  i_cfg_we,
    input  logic [15:0]           i_cfg_wdata
);

    logic                  r_in_vld;
    rafp_pkg::t_in_beat    r_in;
    logic                  r_out_vld;
    rafp_pkg::t_out_beat   r_out;
    logic [15:0]           r_inf_dist;
    rafp_pkg::t_frame_res  res;
    logic                  out_free;
    logic                  adv;
    logic                  in_acc;

    rafp_frame_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (adv),
        .i_beat     (r_in),
        .i_inf_dist (r_inf_dist),
        .o_res      (res)
    );

    always_comb begin
        out_free = !r_out_vld || !i_stall;
        adv = r_in_vld && (!res.last || out_free);
        o_stall = r_in_vld && !adv;
        in_acc = i_valid && !o_stall;
        o_valid = r_out_vld;
        o_out_beat = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_inf_dist <= rafp_pkg::INF_DIST_RESET;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv && res.last) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                r_inf_dist <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_beat;
        end
        if (adv && res.last) begin
            r_out <= res.res;
        end
    end

    a_stall_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |-> !o_stall)
        else $error("input stalled with an empty input register");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_beat)))
        else $error("stalled result beat was lost or changed");

    a_error_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_beat.status == rafp_pkg::ST_ERROR) |-> o_out_beat.distance == 16'd0)
        else $error("parse error beat carries a distance");

    a_ok_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_beat.status == rafp_pkg::ST_OK) |-> o_out_beat.distance < r_inf_dist)
        else $error("measured distance not below the limit");

    a_no_reserved_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_out_beat.status != 2'd3)
        else $error("result beat carries an undefined status");

endmodule

/* design/rafp_frame_parse.sv */
// Per-beat frame state update and end-of-frame result decision.
module rafp_frame_parse (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  rafp_pkg::t_in_beat      i_beat,
    input  logic [15:0]             i_inf_dist,
    output rafp_pkg::t_frame_res    o_res
);

    logic [rafp_pkg::KW_W-1:0]   r_kw_prog, n_kw_prog;
    rafp_pkg::t_phase            r_st_phase, n_st_phase;
    logic [15:0]                 r_st_val, n_st_val;
    logic                        r_st_seen, n_st_seen;
    logic                        r_prev_d, n_prev_d;
    rafp_pkg::t_phase            r_d_phase, n_d_phase;
    logic [15:0]                 r_d_val, n_d_val;
    logic                        r_d_seen, n_d_seen;
    logic                        r_d_ovf, n_d_ovf;
    logic [rafp_pkg::CNT_W-1:0]  r_cnt, n_cnt;

    logic [7:0]                  c;
    logic [3:0]                  dig;
    logic                        c_dig;
    logic                        last;
    logic [rafp_pkg::CNT_W-1:0]  cnt_inc;
    logic [rafp_pkg::PROD_W-1:0] d_prod;
    logic [15:0]                 st_prod;

    always_comb begin
        c = i_beat.rx_byte;
        dig = c[3:0];
        c_dig = rafp_pkg::is_digit(c);
        cnt_inc = r_cnt + 1'b1;
        last = i_beat.frame_end ||
               (cnt_inc >= rafp_pkg::CNT_W'(rafp_pkg::MAX_FRAME_BYTES));
        st_prod = 16'((r_st_val << 3) + (r_st_val << 1) + 16'(dig));
        d_prod = (rafp_pkg::PROD_W'(r_d_val) << 3) + (rafp_pkg::PROD_W'(r_d_val) << 1)
                 + rafp_pkg::PROD_W'(dig);

        n_kw_prog = r_kw_prog;
        n_st_phase = r_st_phase;
        n_st_val = r_st_val;
        n_st_seen = r_st_seen;
        n_prev_d = r_prev_d;
        n_d_phase = r_d_phase;
        n_d_val = r_d_val;
        n_d_seen = r_d_seen;
        n_d_ovf = r_d_ovf;
        n_cnt = cnt_inc;

        case (r_st_phase)
            rafp_pkg::PH_SEARCH: begin
                if (c == rafp_pkg::keyword_char(r_kw_prog)) begin
                    if (r_kw_prog == rafp_pkg::KW_W'(rafp_pkg::KW_LEN - 1)) begin
                        n_kw_prog = '0;
                        if (!last) begin
                            n_st_phase = rafp_pkg::PH_SPACES;
                        end
                    end else begin
                        n_kw_prog = r_kw_prog + 1'b1;
                    end
                end else begin
                    n_kw_prog = (c == rafp_pkg::CH_S) ? rafp_pkg::KW_W'(1) : '0;
                end
            end
            rafp_pkg::PH_SPACES, rafp_pkg::PH_DIGITS: begin
                if (!(r_st_phase == rafp_pkg::PH_SPACES && c == rafp_pkg::CH_SPACE)) begin
                    if (c_dig) begin
                        n_st_val = st_prod;
                        n_st_seen = 1'b1;
                        n_st_phase = rafp_pkg::PH_DIGITS;
                    end else begin
                        n_st_phase = rafp_pkg::PH_DONE;
                    end
                end
            end
            default: begin
            end
        endcase

        case (r_d_phase)
            rafp_pkg::PH_SEARCH: begin
                if (r_prev_d && c == rafp_pkg::CH_COLON) begin
                    n_d_phase = rafp_pkg::PH_SPACES;
                end
                n_prev_d = (c == rafp_pkg::CH_D);
            end
            rafp_pkg::PH_SPACES, rafp_pkg::PH_DIGITS: begin
                if (!(r_d_phase == rafp_pkg::PH_SPACES && c == rafp_pkg::CH_SPACE)) begin
                    if (c_dig) begin
                        n_d_seen = 1'b1;
                        if (d_prod >= rafp_pkg::PROD_W'(i_inf_dist)) begin
                            n_d_ovf = 1'b1;
                            n_d_phase = rafp_pkg::PH_DONE;
                        end else begin
                            n_d_val = d_prod[15:0];
                            n_d_phase = rafp_pkg::PH_DIGITS;
                        end
                    end else begin
                        n_d_phase = rafp_pkg::PH_DONE;
                    end
                end
            end
            default: begin
            end
        endcase

        o_res.last = last;
        o_res.res.status = rafp_pkg::ST_ERROR;
        o_res.res.distance = '0;
        if (cnt_inc < rafp_pkg::CNT_W'(rafp_pkg::MIN_FRAME_BYTES)) begin
            o_res.res.status = rafp_pkg::ST_ERROR;
        end else if (n_st_seen && n_st_val == rafp_pkg::STATUS_FAIL_CODE) begin
            o_res.res.status = rafp_pkg::ST_FAIL;
            o_res.res.distance = i_inf_dist;
        end else if (n_st_seen && n_st_val != 16'd0) begin
            o_res.res.status = rafp_pkg::ST_ERROR;
        end else if (n_d_phase != rafp_pkg::PH_SEARCH && n_d_seen && !n_d_ovf) begin
            o_res.res.status = rafp_pkg::ST_OK;
            o_res.res.distance = n_d_val;
        end

        if (last) begin
            n_kw_prog = '0;
            n_st_phase = rafp_pkg::PH_SEARCH;
            n_st_val = '0;
            n_st_seen = 1'b0;
            n_prev_d = 1'b0;
            n_d_phase = rafp_pkg::PH_SEARCH;
            n_d_val = '0;
            n_d_seen = 1'b0;
            n_d_ovf = 1'b0;
            n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw_prog <= '0;
            r_st_phase <= rafp_pkg::PH_SEARCH;
            r_st_val <= '0;
            r_st_seen <= 1'b0;
            r_prev_d <= 1'b0;
            r_d_phase <= rafp_pkg::PH_SEARCH;
            r_d_val <= '0;
            r_d_seen <= 1'b0;
            r_d_ovf <= 1'b0;
            r_cnt <= '0;
        end else if (i_step) begin
            r_kw_prog <= n_kw_prog;
            r_st_phase <= n_st_phase;
            r_st_val <= n_st_val;
            r_st_seen <= n_st_seen;
            r_prev_d <= n_prev_d;
            r_d_phase <= n_d_phase;
            r_d_val <= n_d_val;
            r_d_seen <= n_d_seen;
            r_d_ovf <= n_d_ovf;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* tb/sv/rafp_frame_checker.sv */
// Checker that watches the parser's beat channels, predicts each frame reading and compares it.
module rafp_frame_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  rafp_pkg::t_in_beat  i_in_beat,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  rafp_pkg::t_out_beat i_out_beat,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    output int                  o_errors,
    output int                  o_waiting,
    output int                  o_beats,
    output int                  o_measured,
    output int                  o_sig_fail,
    output int                  o_parse_err
);
    import rafp_pkg::*;

    localparam logic [47:0] KEYWORD = "State;";

    logic [15:0] dist_limit;
    logic [2:0]  kw_matched;
    t_phase      st_phase;
    t_phase      dist_phase;
    logic [15:0] st_value;
    logic [15:0] dist_value;
    logic        st_digit_seen;
    logic        dist_digit_seen;
    logic        dist_over;
    logic        prev_was_d;
    logic [8:0]  frame_bytes;
    t_out_beat   readings_due[$];

    task automatic start_frame();
        kw_matched      = '0;
        st_phase        = PH_SEARCH;
        dist_phase      = PH_SEARCH;
        st_value        = '0;
        dist_value      = '0;
        st_digit_seen   = 1'b0;
        dist_digit_seen = 1'b0;
        dist_over       = 1'b0;
        prev_was_d      = 1'b0;
        frame_bytes     = '0;
    endtask

    task automatic consume_byte(input logic [7:0] c, input logic fe);
        logic        last;
        logic [19:0] acc;
        t_out_beat   rd;
        frame_bytes = frame_bytes + 9'd1;
        last = fe || (frame_bytes >= MAX_FRAME_BYTES);

        case (st_phase)
            PH_SEARCH: begin
                if (c == KEYWORD[47 - 8 * kw_matched -: 8]) begin
                    if (kw_matched == KW_LEN - 1) begin
                        kw_matched = '0;
                        if (!last) st_phase = PH_SPACES;
                    end else begin
                        kw_matched = kw_matched + 3'd1;
                    end
                end else begin
                    kw_matched = (c == CH_S) ? 3'd1 : 3'd0;
                end
            end
            PH_SPACES, PH_DIGITS: begin
                if (st_phase == PH_DIGITS || c != CH_SPACE) begin
                    if (c >= CH_ZERO && c <= CH_NINE) begin
                        st_value      = st_value * 16'd10 + {8'd0, c - CH_ZERO};
                        st_digit_seen = 1'b1;
                        st_phase      = PH_DIGITS;
                    end else begin
                        st_phase = PH_DONE;
                    end
                end
            end
            default: ;
        endcase

        case (dist_phase)
            PH_SEARCH: begin
                if (prev_was_d && c == CH_COLON) dist_phase = PH_SPACES;
                prev_was_d = (c == CH_D);
            end
            PH_SPACES, PH_DIGITS: begin
                if (dist_phase == PH_DIGITS || c != CH_SPACE) begin
                    if (c >= CH_ZERO && c <= CH_NINE) begin
                        acc             = dist_value * 20'd10 + {12'd0, c - CH_ZERO};
                        dist_digit_seen = 1'b1;
                        dist_phase      = PH_DIGITS;
                        if (acc >= {4'd0, dist_limit}) begin
                            dist_over  = 1'b1;
                            dist_phase = PH_DONE;
                        end else begin
                            dist_value = acc[15:0];
                        end
                    end else begin
                        dist_phase = PH_DONE;
                    end
                end
            end
            default: ;
        endcase

        if (last) begin
            rd.status   = ST_ERROR;
            rd.distance = '0;
            if (frame_bytes >= MIN_FRAME_BYTES) begin
                if (st_digit_seen && st_value == STATUS_FAIL_CODE) begin
                    rd.status   = ST_FAIL;
                    rd.distance = dist_limit;
                end else if (!(st_digit_seen && st_value != 16'd0) &&
                             dist_phase != PH_SEARCH && dist_digit_seen && !dist_over) begin
                    rd.status   = ST_OK;
                    rd.distance = dist_value;
                end
            end
            readings_due.push_back(rd);
            start_frame();
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_beat want;
        if (!i_rst_n) begin
            dist_limit  = INF_DIST_RESET;
            start_frame();
            readings_due.delete();
            o_errors    = 0;
            o_beats     = 0;
            o_measured  = 0;
            o_sig_fail  = 0;
            o_parse_err = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (readings_due.size() == 0) begin
                    o_errors++;
                    $display("%0t unexpected reading: expected none, got status %0d distance %0d",
                             $time, i_out_beat.status, i_out_beat.distance);
                end else begin
                    want = readings_due.pop_front();
                    if (i_out_beat.status !== want.status) begin
                        o_errors++;
                        $display("%0t status mismatch: expected %0d, got %0d",
                                 $time, want.status, i_out_beat.status);
                    end
                    if (i_out_beat.distance !== want.distance) begin
                        o_errors++;
                        $display("%0t distance mismatch: expected %0d, got %0d",
                                 $time, want.distance, i_out_beat.distance);
                    end
                    case (want.status)
                        ST_OK:   o_measured++;
                        ST_FAIL: o_sig_fail++;
                        default: o_parse_err++;
                    endcase
                end
            end
            if (i_in_valid && !i_in_stall) begin
                o_beats++;
                consume_byte(i_in_beat.rx_byte, i_in_beat.frame_end);
            end
            if (i_cfg_we) dist_limit = i_cfg_wdata;
        end
        o_waiting = readings_due.size();
    end

endmodule

/* tb/sv/rangefinder_ascii_frame_parser_core_tb.sv */
// Testbench top that drives rangefinder frames and limit settings into the parser and gives the verdict.
module rangefinder_ascii_frame_parser_core_tb;
    import rafp_pkg::*;

    localparam int PHASES       = 8;
    localparam int PHASE_BEATS  = 105;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 600000;
    localparam logic [8*15-1:0] NOISE_CHARS = "State;d: 0259x,";

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_in_beat    i_in_beat = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_out_beat   o_out_beat;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    logic        hold_req = 1'b0;
    int          tx_mode = 0;
    int          rx_mode = 0;
    int          cur_limit = 65535;
    int          beats_sent = 0;
    int          cycle_count = 0;
    int          settings_used = 0;
    logic [7:0]  frame_q[$];

    int          errors;
    int          waiting;
    int          beats;
    int          measured;
    int          sig_fail;
    int          parse_err;

    rangefinder_ascii_frame_parser_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_beat   (i_in_beat),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_beat  (o_out_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    rafp_frame_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_in_beat   (i_in_beat),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_out_beat  (o_out_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_errors    (errors),
        .o_waiting   (waiting),
        .o_beats     (beats),
        .o_measured  (measured),
        .o_sig_fail  (sig_fail),
        .o_parse_err (parse_err)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("rangefinder_ascii_frame_parser_core_tb: FAIL");
            $finish;
        end
    end

    function automatic int pick_gap(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0 || r < (mode == 1 ? 80 : 45)) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] noise_byte();
        int k;
        if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
        k = $urandom_range(0, 14);
        return NOISE_CHARS[8 * k +: 8];
    endfunction

    function automatic int pick_status();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 65) return 2;
        if (r < 75) return 1;
        if (r < 82) return 65538;
        if (r < 86) return 65536;
        return $urandom_range(0, 200000);
    endfunction

    function automatic int pick_distance();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return $urandom_range(0, (cur_limit > 0) ? cur_limit - 1 : 0);
        if (r < 55) return $urandom_range(0, 9);
        if (r < 65) return (cur_limit > 0) ? cur_limit - 1 : 0;
        if (r < 75) return cur_limit;
        if (r < 82) return cur_limit + 1;
        return $urandom_range(0, 999999);
    endfunction

    task automatic push_str(input string s);
        for (int k = 0; k < s.len(); k++) frame_q.push_back(s[k]);
    endtask

    task automatic push_spaces();
        int r;
        r = $urandom_range(0, 99);
        if (r >= 90) repeat ($urandom_range(2, 5)) frame_q.push_back(CH_SPACE);
        else if (r >= 60) frame_q.push_back(CH_SPACE);
    endtask

    task automatic push_separator();
        case ($urandom_range(0, 3))
            0: push_str(" ");
            1: push_str(",");
            2: push_str("; ");
            default: ;
        endcase
    endtask

    task automatic push_number(input int v);
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) frame_q.push_back(CH_ZERO);
        push_str($sformatf("%0d", v));
        if ($urandom_range(0, 19) == 0)
            repeat ($urandom_range(4, 10)) frame_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    endtask

    task automatic add_status_field();
        push_str("State;");
        push_spaces();
        push_number(pick_status());
    endtask

    task automatic add_distance_field();
        push_str("d:");
        push_spaces();
        push_number(pick_distance());
    endtask

    task automatic add_long_frame(input int min_len);
        int n;
        n = $urandom_range(min_len, 300);
        add_distance_field();
        push_separator();
        while (frame_q.size() < n) frame_q.push_back(noise_byte());
    endtask

    task automatic build_frame();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        frame_q.delete();
        if (kind < 60) begin
            if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 4)) frame_q.push_back(noise_byte());
            if ($urandom_range(0, 1) == 0) begin
                if ($urandom_range(0, 3) != 0) begin
                    add_status_field();
                    push_separator();
                end
                add_distance_field();
            end else begin
                add_distance_field();
                push_separator();
                if ($urandom_range(0, 3) != 0) add_status_field();
            end
            if ($urandom_range(0, 2) == 0) push_str(" mm");
        end else if (kind < 68) begin
            push_str("State;");
            push_spaces();
            add_distance_field();
        end else if (kind < 75) begin
            add_status_field();
            push_separator();
            add_distance_field();
            push_separator();
            add_status_field();
            push_separator();
            add_distance_field();
        end else if (kind < 85) begin
            case ($urandom_range(0, 5))
                0: push_str("Stat;");
                1: push_str("SState;");
                2: push_str("State :");
                3: push_str("d :");
                4: push_str("dd:");
                default: push_str("Sta d:");
            endcase
            push_number(pick_distance());
            if ($urandom_range(0, 1) == 0) begin
                push_separator();
                add_distance_field();
            end
        end else if (kind < 98) begin
            repeat ($urandom_range(1, 16)) frame_q.push_back(noise_byte());
        end else begin
            add_long_frame(250);
        end
        if (frame_q.size() > 1 && $urandom_range(0, 15) == 0) begin
            n = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > n) void'(frame_q.pop_back());
        end
    endtask

    task automatic send_beat(input logic [7:0] b, input logic fe);
        int gap;
        gap = pick_gap(tx_mode);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_beat <= '{rx_byte: b, frame_end: fe};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame();
        foreach (frame_q[k]) send_beat(frame_q[k], k == frame_q.size() - 1);
    endtask

    task automatic send_text(input string s);
        frame_q.delete();
        push_str(s);
        send_frame();
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (waiting != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        cur_limit = v;
        settings_used++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : result_side
        int run_left;
        int r;
        run_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_stall  <= 1'b0;
                hold_req <= 1'b0;
                run_left = 0;
            end else if (run_left > 0) begin
                run_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (rx_mode == 0) begin
                    i_stall <= 1'b0;
                    run_left = $urandom_range(4, 30);
                end else if (r < (rx_mode == 1 ? 85 : 55)) begin
                    i_stall <= 1'b0;
                    run_left = $urandom_range(0, 5);
                end else if (r < 97) begin
                    i_stall <= 1'b1;
                    run_left = $urandom_range(0, 3);
                end else begin
                    i_stall <= 1'b1;
                    run_left = $urandom_range(10, 40);
                end
            end
        end
    end

    initial begin : stimulus
        int          ph;
        int          target;
        logic [15:0] lim;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        frame_q.delete();
        frame_q.push_back(8'hFF);
        send_frame();
        frame_q.delete();
        frame_q.push_back(8'h00);
        frame_q.push_back(8'h00);
        send_frame();
        send_text("d:7");
        send_text("State;");
        send_text("State;2");

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: lim = 16'd65535;
                1: lim = 16'd1000;
                2: lim = 16'd1;
                3: lim = 16'd0;
                4: lim = 16'd9;
                5: lim = 16'd65534;
                6: lim = 16'($urandom_range(2, 65533));
                default: lim = 16'd65535;
            endcase
            write_limit(lim);
            tx_mode = ph % 3;
            rx_mode = (ph + 1) % 3;
            target = beats_sent + PHASE_BEATS;
            if (ph == 1) begin
                hold_req <= 1'b1;
                repeat (16) begin
                    frame_q.delete();
                    add_distance_field();
                    send_frame();
                end
            end
            if (ph == 5) begin
                frame_q.delete();
                add_long_frame(MAX_FRAME_BYTES + 4);
                send_frame();
            end
            while (beats_sent < target) begin
                build_frame();
                send_frame();
            end
        end
        drain_results();

        $display("Sent %0d beats over %0d limit settings, with random gaps and a long result hold.",
                 beats, settings_used);
        $display("Checked %0d readings: %0d measured, %0d signal fail, %0d parse error.",
                 measured + sig_fail + parse_err, measured, sig_fail, parse_err);
        if (errors == 0 && waiting == 0) begin
            $display("rangefinder_ascii_frame_parser_core_tb: PASS");
        end else begin
            $display("rangefinder_ascii_frame_parser_core_tb: FAIL");
        end
        $finish;
    end

endmodule
